// ----- hw/rtl/pfac_pkg.sv -----
// Shared types and constants for the packet framer with additive checksum.
`timescale 1ns / 1ps
`default_nettype none

package pfac_pkg;

    // Sync bytes that open every packet: 'S', 'N', 'P'.
    localparam logic [7:0] SYNC_0 = 8'h53;
    localparam logic [7:0] SYNC_1 = 8'h4E;
    localparam logic [7:0] SYNC_2 = 8'h50;

    // Step codes of the back-end byte sequencer.
    localparam logic [2:0] STEP_SYNC_0 = 3'd0;
    localparam logic [2:0] STEP_SYNC_1 = 3'd1;
    localparam logic [2:0] STEP_SYNC_2 = 3'd2;
    localparam logic [2:0] STEP_ID     = 3'd3;
    localparam logic [2:0] STEP_LEN    = 3'd4;
    localparam logic [2:0] STEP_BYTE   = 3'd5;
    localparam logic [2:0] STEP_CHK    = 3'd6;

    typedef struct packed {
        logic [7:0] packet_id;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_run;
        logic       end_of_packet;
    } out_item_t;

    // One classified input item, as queued between front and back.
    typedef struct packed {
        logic       first;     // opens a packet: send header
        logic       zero_len;  // header and checksum only
        logic       has_chk;   // checksum follows this item's bytes
        logic [7:0] packet_id;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
        logic [7:0] checksum;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pfac_front.sv -----
// Front end: tracks packet position and checksum, classifies each input item.
`timescale 1ns / 1ps
`default_nettype none

module pfac_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pfac_pkg::in_item_t item,
    input  wire logic             accept,
    output pfac_pkg::cmd_t        cmd
);

    logic [7:0] remaining_reg;
    logic [7:0] remaining_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    logic       first;
    logic [7:0] base_sum;
    logic [7:0] base_rem;
    logic [7:0] new_sum;
    logic [7:0] new_rem;

    always_comb
    begin
        first    = (remaining_reg == 8'd0);
        base_sum = first ? (item.packet_id + item.payload_length) : sum_reg;
        base_rem = first ? item.payload_length : remaining_reg;
        new_sum  = base_sum + item.payload_byte;
        new_rem  = base_rem - 8'd1;

        cmd.first          = first;
        cmd.zero_len       = first && (item.payload_length == 8'd0);
        cmd.has_chk        = cmd.zero_len || (new_rem == 8'd0);
        cmd.packet_id      = item.packet_id;
        cmd.payload_length = item.payload_length;
        cmd.payload_byte   = item.payload_byte;
        cmd.checksum       = cmd.zero_len ? base_sum : new_sum;

        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        if (accept)
        begin
            if (cmd.has_chk)
            begin
                // packet closes here: back to idle
                remaining_next = 8'd0;
                sum_next       = 8'd0;
            end
            else
            begin
                remaining_next = new_rem;
                sum_next       = new_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= 8'd0;
            sum_reg       <= 8'd0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pfac_cmd_fifo.sv -----
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pfac_cmd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire pfac_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output pfac_pkg::cmd_t     rd_data,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pfac_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pfac_back.sv -----
// Back end: expands queued commands into framed bytes, one per cycle while a command is queued and the output is free.
`timescale 1ns / 1ps
`default_nettype none

module pfac_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pfac_pkg::cmd_t cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_done,
    output pfac_pkg::out_item_t result,
    output logic                empty,
    input  wire logic           pop
);

    logic                busy_reg;
    logic                busy_next;
    logic [2:0]          step_reg;
    logic [2:0]          step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    pfac_pkg::out_item_t out_reg;
    pfac_pkg::out_item_t out_next;

    logic       slot_free;
    logic       advance;
    logic [2:0] step;
    logic [7:0] tx;
    logic       last;
    logic       eop;

    assign slot_free = !out_valid_reg || pop;
    assign advance   = cmd_valid && slot_free;
    assign cmd_done  = advance && last;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        if (busy_reg)
        begin
            step = step_reg;
        end
        else
        begin
            step = cmd.first ? pfac_pkg::STEP_SYNC_0 : pfac_pkg::STEP_BYTE;
        end

        tx   = 8'h00;
        last = 1'b0;
        eop  = 1'b0;
        unique case (step)
            pfac_pkg::STEP_SYNC_0: tx = pfac_pkg::SYNC_0;
            pfac_pkg::STEP_SYNC_1: tx = pfac_pkg::SYNC_1;
            pfac_pkg::STEP_SYNC_2: tx = pfac_pkg::SYNC_2;
            pfac_pkg::STEP_ID:     tx = cmd.packet_id;
            pfac_pkg::STEP_LEN:    tx = cmd.payload_length;
            pfac_pkg::STEP_BYTE:
            begin
                // zero length skips the payload byte and sends the checksum
                tx   = cmd.zero_len ? cmd.checksum : cmd.payload_byte;
                last = cmd.zero_len || !cmd.has_chk;
                eop  = cmd.zero_len;
            end
            pfac_pkg::STEP_CHK:
            begin
                tx   = cmd.checksum;
                last = 1'b1;
                eop  = 1'b1;
            end
            default:
            begin
                tx   = 8'h00;
                last = 1'b1;
                eop  = 1'b0;
            end
        endcase

        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next         = 1'b1;
            out_next.tx_byte       = tx;
            out_next.last_of_run   = last;
            out_next.end_of_packet = eop;
            busy_next              = !last;
            step_next              = step + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= pfac_pkg::STEP_SYNC_0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/packet_framer_additive_checksum_unit.sv -----
// Top level of the packet framer with additive checksum.
`timescale 1ns / 1ps
`default_nettype none

// Frames payload bytes for a serial link. Push one item per payload byte; the
// first item of a packet carries id and length and yields 'S','N','P', id,
// length and the byte (plus the checksum when the length is one). Later items
// yield their byte, and the last one also the checksum, the sum modulo 256 of
// id, length and all payload bytes. A zero length yields header and checksum
// only. Result bytes leave at one per cycle while the receiver pops them, from
// a byte sequencer behind a QUEUE_DEPTH-entry command queue. Input is taken
// every cycle while the queue has room.
module packet_framer_additive_checksum_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire pfac_pkg::in_item_t item,
    output logic                    empty,
    input  wire logic               pop,
    output pfac_pkg::out_item_t     result
);

    pfac_pkg::cmd_t front_cmd;
    pfac_pkg::cmd_t head_cmd;
    logic           accept;
    logic           queue_empty;
    logic           cmd_done;

    assign accept = push && !full;

    pfac_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .accept (accept),
        .cmd    (front_cmd)
    );

    pfac_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (cmd_done),
        .rd_data (head_cmd),
        .empty   (queue_empty)
    );

    pfac_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (!queue_empty),
        .cmd_done  (cmd_done),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

// ----- sim/framer_checker.sv -----
// Scoreboard for the packet framer: predicts framed bytes and checks each result transfer.
`timescale 1ns / 1ps

module framer_checker
    import pfac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire logic      full,
    input  wire in_item_t  item,
    input  wire logic      empty,
    input  wire logic      pop,
    input  wire out_item_t result,
    output int             mismatches,
    output int             bytes_due
);

    out_item_t  frame_q[$];
    logic [7:0] bytes_left;
    logic [7:0] sum_acc;

    task automatic report(input string msg);
        $display("[%0t] framer_checker: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last, input logic eop);
        out_item_t r;
        r.tx_byte       = b;
        r.last_of_run   = last;
        r.end_of_packet = eop;
        frame_q.push_back(r);
    endtask

    // Expand one accepted item into the bytes it puts on the link.
    task automatic frame_item(input in_item_t it);
        if (bytes_left == 8'd0) begin
            queue_byte(SYNC_0, 1'b0, 1'b0);
            queue_byte(SYNC_1, 1'b0, 1'b0);
            queue_byte(SYNC_2, 1'b0, 1'b0);
            queue_byte(it.packet_id, 1'b0, 1'b0);
            queue_byte(it.payload_length, 1'b0, 1'b0);
            sum_acc = it.packet_id + it.payload_length;
            if (it.payload_length == 8'd0) begin
                // header and checksum only; the payload byte is dropped
                queue_byte(sum_acc, 1'b1, 1'b1);
                sum_acc = 8'd0;
                return;
            end
            bytes_left = it.payload_length;
        end
        sum_acc    = sum_acc + it.payload_byte;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
            queue_byte(it.payload_byte, 1'b0, 1'b0);
            queue_byte(sum_acc, 1'b1, 1'b1);
            sum_acc = 8'd0;
        end
        else begin
            queue_byte(it.payload_byte, 1'b1, 1'b0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            frame_q.delete();
            bytes_left = 8'd0;
            sum_acc    = 8'd0;
        end
        else begin
            if (push && !full)
                frame_item(item);
            if (pop && !empty) begin
                if (frame_q.size() == 0) begin
                    report($sformatf("unexpected result %h", result));
                end
                else begin
                    want = frame_q.pop_front();
                    if (result.tx_byte !== want.tx_byte)
                        report($sformatf("tx_byte %h, want %h",
                                         result.tx_byte, want.tx_byte));
                    if (result.last_of_run !== want.last_of_run)
                        report($sformatf("last_of_run %b, want %b",
                                         result.last_of_run, want.last_of_run));
                    if (result.end_of_packet !== want.end_of_packet)
                        report($sformatf("end_of_packet %b, want %b",
                                         result.end_of_packet, want.end_of_packet));
                end
            end
        end
        bytes_due = frame_q.size();
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the packet framer: clock, reset, packet stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module tb;
    import pfac_pkg::*;

    typedef enum int {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_PATTERN} pop_mode_e;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  item;
    logic      empty;
    logic      pop;
    out_item_t result;

    int fail_count;
    int bytes_due;
    int items_sent;
    int burst_left;
    bit no_gaps;

    packet_framer_additive_checksum_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    framer_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (fail_count),
        .bytes_due  (bytes_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one item, sometimes idling first when the current burst is used up.
    task automatic send_item(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                push = 1'b0;
                item = in_item_t'(24'($urandom));
            end
        end
        burst_left--;
        @(negedge clk);
        push                = 1'b1;
        item.packet_id      = id;
        item.payload_length = len;
        item.payload_byte   = b;
        do
            @(posedge clk);
        while (full);
        items_sent++;
    endtask

    // Later items carry random id and length, which must be ignored.
    task automatic send_packet(input logic [7:0] id, input logic [7:0] len);
        send_item(id, len, 8'($urandom));
        for (int k = 1; k < int'(len); k++)
            send_item(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin : stimulus
        int pick;
        logic [7:0] len;
        rst_n      = 1'b0;
        push       = 1'b0;
        item       = '0;
        items_sent = 0;
        burst_left = 0;
        no_gaps    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero length: byte ignored, checksum of id and length alone
        send_item(8'h00, 8'h00, 8'hFF);
        send_item(8'hFF, 8'h00, 8'h00);
        // length one: header, byte and checksum from a single item
        send_item(8'hFF, 8'h01, 8'hFF);
        send_item(8'h80, 8'h02, 8'h01);
        send_item(8'hFF, 8'hFF, 8'h7F);
        send_item(8'h01, 8'h03, 8'h00);
        send_item(8'h00, 8'h00, 8'hFF);
        send_item(8'hFF, 8'hFF, 8'h80);
        send_item(8'hAA, 8'h01, 8'h55);
        send_item(8'h55, 8'h00, 8'hAA);
        send_item(8'h7F, 8'h04, 8'hFE);
        send_item(8'h00, 8'h00, 8'h01);
        send_item(8'hFF, 8'hFF, 8'hFF);
        send_item(8'h01, 8'h01, 8'h00);

        // random packets, mostly short; one stretch with no idling
        while (items_sent < 120)
        begin
            no_gaps = (items_sent >= 90 && items_sent < 120);
            pick = $urandom_range(0, 7);
            if (pick == 0)
                len = 8'd0;
            else if (pick < 6)
                len = 8'($urandom_range(1, 6));
            else
                len = 8'($urandom_range(7, 48));
            send_packet(8'($urandom), len);
        end
        send_packet(8'($urandom), 8'($urandom_range(120, 160)));

        @(negedge clk);
        push = 1'b0;
        while (bytes_due != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && bytes_due == 0)
            $display("[packet_framer_additive_checksum_unit] OK");
        else
            $display("[packet_framer_additive_checksum_unit] ERROR");
        $finish;
    end

    initial
    begin : receiver
        pop_mode_e  mode;
        int         mode_left;
        int         hold_left;
        bit         held;
        logic [7:0] pat;
        pop       = 1'b0;
        mode      = POP_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        pat       = 8'b1011_0010;
        forever
        begin
            @(negedge clk);
            // hold off once for a long stretch so the input side fills and stalls
            if (!held && items_sent >= 60)
            begin
                held      = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = pop_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 64);
                    pat       = 8'($urandom);
                end
                mode_left--;
                case (mode)
                    POP_ALWAYS: pop = 1'b1;
                    POP_HALF:   pop = 1'($urandom_range(0, 1));
                    POP_SPARSE: pop = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        pat = {pat[6:0], pat[7]};
                        pop = pat[0] | (pat == 8'd0);
                    end
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("[packet_framer_additive_checksum_unit] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pfac_pkg.sv
hw/rtl/pfac_front.sv
hw/rtl/pfac_cmd_fifo.sv
hw/rtl/pfac_back.sv
hw/rtl/packet_framer_additive_checksum_unit.sv
sim/framer_checker.sv
sim/tb.sv
